// ===== src/tracker_pattern_unpacker_core_assert.svh =====
// Assertion helpers shared by the unpacker modules.
`ifndef TRACKER_PATTERN_UNPACKER_CORE_ASSERT_SVH
`define TRACKER_PATTERN_UNPACKER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define TPU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define TPU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define TPU_ASSERT_IMP(lbl, ante, cons)
`define TPU_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== src/tpu_pkg.sv =====
package tpu_pkg;

  typedef enum logic {
    KIND_START,
    KIND_DATA
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] byte_count;
    logic [7:0]  data_byte;
  } item_t;

  localparam logic [7:0] ABSENT = 8'hFF;
  localparam int FIELD_COUNT = 5;

  typedef logic [FIELD_COUNT-1:0][7:0] cell_fields_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

endpackage

// ===== src/tpu_if.sv =====
interface tpu_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] byte_count;
  logic [7:0]  data_byte;

  modport source (output valid, action, byte_count, data_byte, input ready);
  modport sink   (input valid, action, byte_count, data_byte, output ready);
endinterface

interface tpu_out_if;
  logic       valid;
  logic       ready;
  logic       cell_valid;
  logic [5:0] row_index;
  logic [4:0] channel_index;
  logic [7:0] note_value;
  logic [7:0] instrument_value;
  logic [7:0] volume_value;
  logic [7:0] effect_command;
  logic [7:0] effect_operand;
  logic       pattern_done;

  modport source (output valid, cell_valid, row_index, channel_index, note_value,
                  instrument_value, volume_value, effect_command, effect_operand,
                  pattern_done, input ready);
  modport sink   (input valid, cell_valid, row_index, channel_index, note_value,
                  instrument_value, volume_value, effect_command, effect_operand,
                  pattern_done, output ready);
endinterface

// ===== src/tpu_front.sv =====
module tpu_front (
  tpu_in_if.sink         pattern_in,
  input  logic           full,
  output logic           push,
  output tpu_pkg::item_t item
);

  always_comb begin
    pattern_in.ready = !full;
    push = pattern_in.valid && !full;
    // classify the request: start of a pattern or one data byte
    item.kind = pattern_in.action ? tpu_pkg::KIND_DATA : tpu_pkg::KIND_START;
    item.byte_count = pattern_in.byte_count;
    item.data_byte = pattern_in.data_byte;
  end

endmodule

// ===== src/tpu_queue.sv =====
`include "tracker_pattern_unpacker_core_assert.svh"

module tpu_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tpu_pkg::item_t push_item,
  output logic           full,
  output logic           head_valid,
  output tpu_pkg::item_t head_item,
  input  logic           pop
);

  tpu_pkg::item_t               slots [tpu_pkg::QUEUE_DEPTH];
  logic [tpu_pkg::QPTR_W-1:0]   wr_ptr;
  logic [tpu_pkg::QPTR_W-1:0]   rd_ptr;
  logic [tpu_pkg::QCNT_W-1:0]   count;

  localparam logic [tpu_pkg::QCNT_W-1:0] FULL_COUNT =
    tpu_pkg::QCNT_W'(tpu_pkg::QUEUE_DEPTH);
  localparam logic [tpu_pkg::QCNT_W-1:0] COUNT_ONE = tpu_pkg::QCNT_W'(1);

  assign full = (count == FULL_COUNT);
  assign head_valid = (count != '0);
  assign head_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + COUNT_ONE;
        2'b01:   count <= count - COUNT_ONE;
        default: count <= count;
      endcase
    end
  end

  `TPU_ASSERT_IMP(a_count_bound, 1'b1, count <= FULL_COUNT)
  `TPU_ASSERT_IMP(a_pop_nonempty, pop, head_valid)

endmodule

// ===== src/tpu_back.sv =====
`include "tracker_pattern_unpacker_core_assert.svh"

module tpu_back #(
  parameter int ROWS_PER_PATTERN = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  tpu_pkg::item_t head_item,
  output logic           pop,
  tpu_out_if.source      cell_out
);

  localparam int ROW_W = $clog2(ROWS_PER_PATTERN + 1);
  localparam logic [ROW_W-1:0] ROW_LIMIT = ROW_W'(ROWS_PER_PATTERN);
  localparam logic [ROW_W-1:0] ROW_ONE = ROW_W'(1);
  localparam tpu_pkg::cell_fields_t ALL_ABSENT = {tpu_pkg::FIELD_COUNT{tpu_pkg::ABSENT}};

  typedef enum logic [2:0] {
    PH_FLAG,
    PH_NOTE,
    PH_INSTR,
    PH_VOL,
    PH_CMD,
    PH_OPER
  } phase_t;

  logic [ROW_W-1:0]      current_row, current_row_next;
  logic [15:0]           bytes_left, bytes_left_next;
  phase_t                phase, phase_next;
  logic [2:0]            pending_flags, pending_flags_next;
  logic [4:0]            pending_channel, pending_channel_next;
  tpu_pkg::cell_fields_t cell_fields, cell_fields_next;
  logic                  finished, finished_next;

  logic                  out_valid;
  logic                  emit;
  logic                  emit_cell;
  tpu_pkg::cell_fields_t emit_fields;
  logic [15:0]           bytes_dec;
  logic [ROW_W+5:0]      row_ext;
  logic [7:0]            b;

  // first announced field group after the given position
  function automatic phase_t pick(input logic [2:0] flags, input phase_t from);
    phase_t res;
    res = PH_FLAG;
    if (from == PH_FLAG && flags[0]) begin
      res = PH_NOTE;
    end else if ((from == PH_FLAG || from == PH_INSTR) && flags[1]) begin
      res = PH_VOL;
    end else if (from != PH_CMD && from != PH_OPER && flags[2]) begin
      res = PH_CMD;
    end
    return res;
  endfunction

  assign pop = head_valid && (!out_valid || cell_out.ready);
  assign b = head_item.data_byte;
  assign bytes_dec = (bytes_left != 16'd0) ? bytes_left - 16'd1 : 16'd0;
  assign row_ext = {6'd0, current_row};

  always_comb begin
    current_row_next = current_row;
    bytes_left_next = bytes_left;
    phase_next = phase;
    pending_flags_next = pending_flags;
    pending_channel_next = pending_channel;
    cell_fields_next = cell_fields;
    finished_next = finished;
    emit = 1'b0;
    emit_cell = 1'b0;
    emit_fields = cell_fields;
    if (pop) begin
      case (head_item.kind)
        tpu_pkg::KIND_START: begin
          current_row_next = '0;
          bytes_left_next = head_item.byte_count;
          phase_next = PH_FLAG;
          pending_flags_next = 3'd0;
          pending_channel_next = 5'd0;
          cell_fields_next = ALL_ABSENT;
          finished_next = (head_item.byte_count == 16'd0);
          emit = (head_item.byte_count == 16'd0);
        end
        tpu_pkg::KIND_DATA: begin
          if (!finished) begin
            bytes_left_next = bytes_dec;
            if (phase == PH_FLAG) begin
              if (b == 8'd0) begin
                current_row_next = current_row + ROW_ONE;
              end else begin
                pending_channel_next = b[4:0];
                pending_flags_next = b[7:5];
                cell_fields_next = ALL_ABSENT;
                phase_next = pick(b[7:5], PH_FLAG);
              end
              if (phase_next == PH_FLAG &&
                  (bytes_dec == 16'd0 || current_row_next >= ROW_LIMIT)) begin
                finished_next = 1'b1;
                emit = 1'b1;
              end
            end else begin
              case (phase)
                PH_NOTE: begin
                  emit_fields[0] = b;
                  phase_next = PH_INSTR;
                end
                PH_INSTR: begin
                  emit_fields[1] = b;
                  phase_next = pick(pending_flags, PH_INSTR);
                end
                PH_VOL: begin
                  emit_fields[2] = b;
                  phase_next = pick(pending_flags, PH_VOL);
                end
                PH_CMD: begin
                  emit_fields[3] = b;
                  phase_next = PH_OPER;
                end
                PH_OPER: begin
                  emit_fields[4] = b;
                  phase_next = PH_FLAG;
                end
                default: phase_next = PH_FLAG;
              endcase
              cell_fields_next = emit_fields;
              // last announced byte: emit the cell and run the done test
              if (phase_next == PH_FLAG) begin
                emit = 1'b1;
                emit_cell = 1'b1;
                cell_fields_next = ALL_ABSENT;
                if (bytes_dec == 16'd0 || current_row >= ROW_LIMIT) begin
                  finished_next = 1'b1;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_row <= '0;
      bytes_left <= 16'd0;
      phase <= PH_FLAG;
      pending_flags <= 3'd0;
      pending_channel <= 5'd0;
      cell_fields <= ALL_ABSENT;
      finished <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      current_row <= current_row_next;
      bytes_left <= bytes_left_next;
      phase <= phase_next;
      pending_flags <= pending_flags_next;
      pending_channel <= pending_channel_next;
      cell_fields <= cell_fields_next;
      finished <= finished_next;
      if (pop && emit) begin
        out_valid <= 1'b1;
      end else if (cell_out.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (pop && emit) begin
      cell_out.cell_valid <= emit_cell;
      cell_out.row_index <= emit_cell ? row_ext[5:0] : 6'd0;
      cell_out.channel_index <= emit_cell ? pending_channel : 5'd0;
      cell_out.note_value <= emit_cell ? emit_fields[0] : tpu_pkg::ABSENT;
      cell_out.instrument_value <= emit_cell ? emit_fields[1] : tpu_pkg::ABSENT;
      cell_out.volume_value <= emit_cell ? emit_fields[2] : tpu_pkg::ABSENT;
      cell_out.effect_command <= emit_cell ? emit_fields[3] : tpu_pkg::ABSENT;
      cell_out.effect_operand <= emit_cell ? emit_fields[4] : tpu_pkg::ABSENT;
      cell_out.pattern_done <= finished_next;
    end
  end

  assign cell_out.valid = out_valid;

  `TPU_ASSERT_IMP(a_done_at_flag, finished, phase == PH_FLAG)
  `TPU_ASSERT_IMP(a_row_bound, 1'b1, current_row <= ROW_LIMIT)
  `TPU_ASSERT_IMP(a_empty_means_done, out_valid && !cell_out.cell_valid, cell_out.pattern_done)
  `TPU_ASSERT_NXT(a_start_active,
    pop && head_item.kind == tpu_pkg::KIND_START && head_item.byte_count != 16'd0,
    !finished && phase == PH_FLAG && current_row == '0)

endmodule

// ===== src/tracker_pattern_unpacker_core.sv =====
// Packed pattern unpacker.
// pattern_in carries requests: action 0 starts a pattern of byte_count bytes,
// action 1 delivers one packed data byte. A request is taken when valid and
// ready are both high.
// cell_out carries one result per completed cell (cell_valid 1, absent fields
// 255) or, when the pattern ends without a cell, one result with cell_valid 0
// and pattern_done 1. Bytes after the end of a pattern give no result.
// A request is classified and pushed into a two-entry queue; the decoder pops
// it when its output register is free and registers any result there. One
// request is taken per cycle, as long as the queue has room; the decoder pops
// one request per cycle whenever the queue holds one and its output register
// is empty or being drained.
// When the receiver stalls, the result holds in the output register, the
// decoder stops popping and the queue fills, then ready drops.
// Reset clears the queue and output register and leaves no pattern active.
module tracker_pattern_unpacker_core #(
  parameter int ROWS_PER_PATTERN = 64
) (
  input  logic       clk,
  input  logic       rst,
  tpu_in_if.sink     pattern_in,
  tpu_out_if.source  cell_out
);

  logic           push;
  logic           full;
  logic           head_valid;
  logic           pop;
  tpu_pkg::item_t push_item;
  tpu_pkg::item_t head_item;

  tpu_front u_front (
    .pattern_in (pattern_in),
    .full       (full),
    .push       (push),
    .item       (push_item)
  );

  tpu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (full),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop)
  );

  tpu_back #(
    .ROWS_PER_PATTERN (ROWS_PER_PATTERN)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .cell_out   (cell_out)
  );

endmodule
